[design/i2c_register_master_assert.svh]
// Assertion macros for the I2C register master checker.
// No dependencies; included by the checker file.
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define I2CRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define I2CRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/i2crm_pkg.sv]
// Shared types and codes for the I2C register master.
// No dependencies; used by the front, engine and top level.
package i2crm_pkg;

    localparam int QDepth = 2;
    localparam logic [7:0] AckLimitReset = 8'd250;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_BEGIN_WR = 2'd1,
        CMD_BEGIN_RD = 2'd2,
        CMD_WR_BYTE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ADDRW = 2'd0,
        KIND_REG   = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_ADDRR = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START     = 5'd1,
        PH_RSTART    = 5'd2,
        PH_TX_ADDRW  = 5'd3,
        PH_TX_REG    = 5'd4,
        PH_TX_DATA   = 5'd5,
        PH_TX_ADDRR  = 5'd6,
        PH_ACK_ADDRW = 5'd7,
        PH_ACK_REG   = 5'd8,
        PH_ACK_DATA  = 5'd9,
        PH_ACK_ADDRR = 5'd10,
        PH_WAIT      = 5'd11,
        PH_RX        = 5'd12,
        PH_MACK      = 5'd13,
        PH_MNACK     = 5'd14,
        PH_STOP      = 5'd15,
        PH_STOPE     = 5'd16
    } t_phase;

    typedef struct packed {
        t_cmd        cmd;
        logic [6:0]  target;
        logic [7:0]  reg_ptr;
        logic [15:0] length;
        logic [7:0]  wr_data;
        logic        sda_in;
    } t_item;

    // head of the queue as seen by the engine
    typedef struct packed {
        logic  avail;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       need_byte;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
    } t_result;

endpackage

[design/i2c_register_master.sv]
// Top level of the I2C register master: input queue plus bus engine.
// Depends on i2crm_pkg, i2crm_front and i2crm_engine.
//
// Input channel (i_valid / o_stall): one item per command. A tick advances
// the bus machine by one timing unit and carries the sampled SDA level;
// begin write / begin read start a transaction when idle; supply byte
// hands over the next write data byte.
// Output channel (o_valid / i_stall): exactly one result per input item,
// in order, giving the SCL/SDA drive to hold and the transaction status.
// Configuration: i_cfg_we writes i_cfg_wdata into the ACK timeout limit;
// write it only while no item is in flight.
// From input accept to result valid, the item lands in the two-entry queue
// and the engine then steps it into its output register.
// Throughput is one item per cycle while the receiver does not stall; the
// engine updates its whole state once per item.
// Reset (synchronous, active low) empties the queue and output register,
// puts the engine in idle and sets the timeout limit to 250.
// When the receiver stalls, the result holds, the engine pauses and the
// queue fills; o_stall rises once both queue entries are occupied.
module i2c_register_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_target,
    input  logic [7:0]  i_reg_ptr,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_wr_data,
    input  logic        i_sda_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_read_last,
    output logic        o_need_byte,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_nack_error
);
    import i2crm_pkg::*;

    t_q_head head;
    logic    pop;
    t_result res;

    i2crm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_target   (i_target),
        .i_reg_ptr  (i_reg_ptr),
        .i_length   (i_length),
        .i_wr_data  (i_wr_data),
        .i_sda_in   (i_sda_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    i2crm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (res)
    );

    assign o_scl        = res.scl;
    assign o_sda_out    = res.sda_out;
    assign o_read_byte  = res.read_byte;
    assign o_read_valid = res.read_valid;
    assign o_read_last  = res.read_last;
    assign o_need_byte  = res.need_byte;
    assign o_busy_res   = res.busy_res;
    assign o_done_res   = res.done_res;
    assign o_nack_error = res.nack_error;

endmodule

[design/i2crm_front.sv]
// Input side of the I2C register master: accepts items, decodes the command
// and holds them in a two-entry queue. Depends on i2crm_pkg.
module i2crm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [6:0]         i_target,
    input  logic [7:0]         i_reg_ptr,
    input  logic [15:0]        i_length,
    input  logic [7:0]         i_wr_data,
    input  logic               i_sda_in,
    output i2crm_pkg::t_q_head o_head,
    input  logic               i_pop
);
    import i2crm_pkg::*;

    t_item r_mem [QDepth];
    logic [$clog2(QDepth)-1:0] r_wptr, r_rptr;
    logic [$clog2(QDepth+1)-1:0] r_count;
    logic  push;
    t_item in_item;

    always_comb begin
        in_item.cmd     = t_cmd'(i_cmd);
        in_item.target  = i_target;
        in_item.reg_ptr = i_reg_ptr;
        in_item.length  = i_length;
        in_item.wr_data = i_wr_data;
        in_item.sda_in  = i_sda_in;
    end

    assign o_stall      = (r_count == QDepth[$clog2(QDepth+1)-1:0]);
    assign push         = i_valid && !o_stall;
    assign o_head.avail = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/i2crm_engine.sv]
// Bus engine of the I2C register master: steps the bit machine once per
// queued item and registers the result. Depends on i2crm_pkg.
module i2crm_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  i2crm_pkg::t_q_head i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output i2crm_pkg::t_result o_res
);
    import i2crm_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_poll, n_poll;
    logic [6:0]  r_taddr, n_taddr;
    logic [7:0]  r_raddr, n_raddr;
    logic        r_is_read, n_is_read;
    logic [8:0]  r_pend, n_pend;
    logic [7:0]  r_limit;
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        do_tx, do_nw, n_rvalid, n_rlast, n_done, n_err;
    t_kind       tx_kind;
    logic [7:0]  n_rbyte;
    logic [3:0]  bit_inc;
    logic [7:0]  rx_shift;
    t_item       it;

    assign it      = i_head.item;
    assign o_pop   = i_head.avail && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;
    assign bit_inc = r_bit + 4'd1;
    assign rx_shift = {r_shift[6:0], it.sda_in};

    always_comb begin : next_state
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_poll    = r_poll;
        n_taddr   = r_taddr;
        n_raddr   = r_raddr;
        n_is_read = r_is_read;
        n_pend    = r_pend;
        do_tx     = 1'b0;
        do_nw     = 1'b0;
        tx_kind   = KIND_ADDRW;
        n_rbyte   = 8'd0;
        n_rvalid  = 1'b0;
        n_rlast   = 1'b0;
        n_done    = 1'b0;
        n_err     = 1'b0;

        if (it.cmd == CMD_BEGIN_WR || it.cmd == CMD_BEGIN_RD) begin
            if (r_phase == PH_IDLE) begin
                n_taddr   = it.target;
                n_raddr   = it.reg_ptr;
                n_left    = it.length;
                n_is_read = (it.cmd == CMD_BEGIN_RD);
                n_pend    = 9'd0;
                n_bit     = 4'd0;
                n_poll    = 8'd0;
                n_phase   = PH_START;
                n_tick    = 2'd0;
            end
        end else if (it.cmd == CMD_WR_BYTE) begin
            n_pend = {1'b1, it.wr_data};
            if (r_phase == PH_WAIT) begin
                do_tx   = 1'b1;
                tx_kind = KIND_DATA;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_START, PH_RSTART: begin
                    if (r_tick != 2'd3) begin
                        n_tick = r_tick + 2'd1;
                    end else begin
                        do_tx   = 1'b1;
                        tx_kind = (r_phase == PH_START) ? KIND_ADDRW : KIND_ADDRR;
                    end
                end
                PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
                    if (r_tick < 2'd2) begin
                        n_tick = r_tick + 2'd1;
                    end else begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = bit_inc;
                        n_tick  = 2'd0;
                        if (bit_inc[3]) begin
                            n_poll = 8'd0;
                            unique case (r_phase)
                                PH_TX_ADDRW: n_phase = PH_ACK_ADDRW;
                                PH_TX_REG:   n_phase = PH_ACK_REG;
                                PH_TX_DATA:  n_phase = PH_ACK_DATA;
                                default:     n_phase = PH_ACK_ADDRR;
                            endcase
                        end
                    end
                end
                PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR: begin
                    if (r_tick == 2'd0) begin
                        n_tick = 2'd1;
                    end else if (r_tick == 2'd1) begin
                        if (!it.sda_in) begin
                            n_tick = 2'd2;
                        end else if (r_poll >= r_limit) begin
                            n_phase = PH_STOPE;
                            n_tick  = 2'd0;
                        end else begin
                            n_poll = r_poll + 8'd1;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_ACK_ADDRW: begin
                                do_tx   = 1'b1;
                                tx_kind = KIND_REG;
                            end
                            PH_ACK_REG: begin
                                if (r_is_read) begin
                                    n_phase = PH_RSTART;
                                    n_tick  = 2'd0;
                                end else begin
                                    do_nw = 1'b1;
                                end
                            end
                            PH_ACK_DATA: do_nw = 1'b1;
                            default: begin
                                n_tick = 2'd0;
                                if (r_left == 16'd0) begin
                                    n_phase = PH_STOP;
                                end else begin
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                    n_phase = PH_RX;
                                end
                            end
                        endcase
                    end
                end
                PH_WAIT: do_nw = 1'b1;
                PH_RX: begin
                    if (r_tick == 2'd0) begin
                        n_tick = 2'd1;
                    end else begin
                        n_shift = rx_shift;
                        n_bit   = bit_inc;
                        n_tick  = 2'd0;
                        if (bit_inc[3]) begin
                            n_rbyte  = rx_shift;
                            n_rvalid = 1'b1;
                            n_rlast  = (r_left <= 16'd1);
                            if (r_left != 16'd0) begin
                                n_left = r_left - 16'd1;
                            end
                            n_phase = n_rlast ? PH_MNACK : PH_MACK;
                        end
                    end
                end
                PH_MACK: begin
                    if (r_tick == 2'd0) begin
                        n_tick = 2'd1;
                    end else begin
                        n_bit   = 4'd0;
                        n_shift = 8'd0;
                        n_phase = PH_RX;
                        n_tick  = 2'd0;
                    end
                end
                PH_MNACK: begin
                    if (r_tick < 2'd2) begin
                        n_tick = r_tick + 2'd1;
                    end else begin
                        n_phase = PH_STOP;
                        n_tick  = 2'd0;
                    end
                end
                PH_STOP, PH_STOPE: begin
                    if (r_tick < 2'd2) begin
                        n_tick = r_tick + 2'd1;
                    end else begin
                        n_done  = 1'b1;
                        n_err   = (r_phase == PH_STOPE);
                        n_phase = PH_IDLE;
                        n_tick  = 2'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = 2'd0;
                end
            endcase
        end

        // next write byte: stop, send a pending byte, or wait for one
        if (do_nw) begin
            n_tick = 2'd0;
            if (n_left == 16'd0) begin
                n_phase = PH_STOP;
            end else if (n_pend[8]) begin
                do_tx   = 1'b1;
                tx_kind = KIND_DATA;
            end else begin
                n_phase = PH_WAIT;
            end
        end

        if (do_tx) begin
            n_bit  = 4'd0;
            n_tick = 2'd0;
            unique case (tx_kind)
                KIND_ADDRW: begin
                    n_shift = {n_taddr, 1'b0};
                    n_phase = PH_TX_ADDRW;
                end
                KIND_REG: begin
                    n_shift = n_raddr;
                    n_phase = PH_TX_REG;
                end
                KIND_DATA: begin
                    n_shift = n_pend[7:0];
                    n_pend  = 9'd0;
                    if (n_left != 16'd0) begin
                        n_left = n_left - 16'd1;
                    end
                    n_phase = PH_TX_DATA;
                end
                default: begin
                    n_shift = {n_taddr, 1'b1};
                    n_phase = PH_TX_ADDRR;
                end
            endcase
        end
    end

    // line levels held after this step
    always_comb begin : outputs
        n_res            = '0;
        n_res.scl        = 1'b1;
        n_res.sda_out    = 1'b1;
        unique case (n_phase)
            PH_START, PH_RSTART: n_res.sda_out = (n_tick < 2'd2);
            PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
                n_res.scl     = (n_tick == 2'd1);
                n_res.sda_out = n_shift[7];
            end
            PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR:
                n_res.scl = (n_tick != 2'd0);
            PH_WAIT: n_res.scl = 1'b0;
            PH_RX:   n_res.scl = (n_tick == 2'd1);
            PH_MACK: begin
                n_res.scl     = (n_tick == 2'd1);
                n_res.sda_out = 1'b0;
            end
            PH_MNACK: n_res.scl = (n_tick == 2'd2);
            PH_STOP, PH_STOPE: begin
                n_res.scl     = (n_tick != 2'd0);
                n_res.sda_out = (n_tick == 2'd2);
            end
            default: ;
        endcase
        n_res.read_byte  = n_rbyte;
        n_res.read_valid = n_rvalid;
        n_res.read_last  = n_rlast;
        n_res.need_byte  = (n_phase == PH_WAIT);
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.done_res   = n_done;
        n_res.nack_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= 2'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_left      <= 16'd0;
            r_poll      <= 8'd0;
            r_taddr     <= 7'd0;
            r_raddr     <= 8'd0;
            r_is_read   <= 1'b0;
            r_pend      <= 9'd0;
            r_limit     <= AckLimitReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_left    <= n_left;
                r_poll    <= n_poll;
                r_taddr   <= n_taddr;
                r_raddr   <= n_raddr;
                r_is_read <= n_is_read;
                r_pend    <= n_pend;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

[design/i2crm_checker.sv]
// Port-level checks for the I2C register master, bound to the top level.
// Depends on i2c_register_master_assert.svh.
`include "i2c_register_master_assert.svh"

module i2crm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [7:0]  i_cfg_wdata,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic [6:0]  i_target,
    input logic [7:0]  i_reg_ptr,
    input logic [15:0] i_length,
    input logic [7:0]  i_wr_data,
    input logic        i_sda_in,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_scl,
    input logic        o_sda_out,
    input logic [7:0]  o_read_byte,
    input logic        o_read_valid,
    input logic        o_read_last,
    input logic        o_need_byte,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic        o_nack_error
);

    // an error flag only comes with the stop that ends the transaction
    `I2CRM_ASSERT_NOW(a_err_with_done, o_valid && o_nack_error, o_done_res, "nack_error without done")

    // a finished transaction leaves the engine idle
    `I2CRM_ASSERT_NOW(a_done_idle, o_valid && o_done_res, !o_busy_res && !o_read_valid, "done while busy")

    // waiting for a write byte holds SCL low inside a transaction
    `I2CRM_ASSERT_NOW(a_wait_scl_low, o_valid && o_need_byte, !o_scl && o_busy_res, "need_byte with SCL released")

    // a stalled result stays put
    `I2CRM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_read_byte) && $stable(o_scl) && $stable(o_done_res), "stalled result changed")

endmodule

bind i2c_register_master i2crm_checker u_checker (.*);
